@@ design/pzsd_pkg.sv @@
package pzsd_pkg;

    localparam int DIST_W   = 14;
    localparam int STR_W    = 9;
    localparam int ACC_W    = 20;
    localparam int FRAME_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;

    localparam logic [FRAME_W-1:0] RATE_LIMIT_FRAMES = 8'd4;
    localparam logic [FRAME_W-1:0] FRAMES_SAT        = 8'd255;

    typedef logic [1:0] zoom_t;
    localparam zoom_t ZOOM_NONE = 2'd0;
    localparam zoom_t ZOOM_IN   = 2'd1;
    localparam zoom_t ZOOM_OUT  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_MIN_STRENGTH    = 3'd0;
    localparam cfg_idx_t REG_RELEASE_DROP    = 3'd1;
    localparam cfg_idx_t REG_MAX_DELTA       = 3'd2;
    localparam cfg_idx_t REG_FRAME_CAP       = 3'd3;
    localparam cfg_idx_t REG_STEP_SIZE       = 3'd4;
    localparam cfg_idx_t REG_TIGHT_LIMIT     = 3'd5;
    localparam cfg_idx_t REG_WIDE_LIMIT      = 3'd6;
    localparam cfg_idx_t REG_CONTINUE_FRAMES = 3'd7;

endpackage

@@ design/pinch_zoom_step_detector_top.sv @@
// output: a result beat is registered and appears in the cycle after its input beat is taken
// throughput: one frame per cycle while the output is not back-pressured; the tracking
// state updates at the input beat, and the output register takes a new result whenever it is empty or being drained
// reset: aresetn is synchronous, active low; it loads the register defaults,
// clears the baseline, accumulator, zoom flags and output valid, and saturates the frame count
module pinch_zoom_step_detector_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pinch_distance[13:0], pinch_strength[22:14], zero pad
    input  logic [pzsd_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // in_pinch[0], pinch_start[1]
    input  logic [pzsd_pkg::S_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // zoom_step[1:0], zero pad
    output logic [pzsd_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // held_step[0]
    output logic                               m_axis_tuser,
    input  logic                               cfg_we,
    input  logic [pzsd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pzsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pzsd_pkg::*;

    // configuration
    logic [STR_W-1:0]   min_strength_reg, release_drop_reg;
    logic [DIST_W-1:0]  max_delta_reg, frame_cap_reg, step_size_reg;
    logic [DIST_W-1:0]  tight_limit_reg, wide_limit_reg;
    logic [FRAME_W-1:0] continue_frames_reg;

    // tracking state
    logic                    baseline_valid_reg, baseline_valid_next;
    logic [DIST_W-1:0]       prev_distance_reg, prev_distance_next;
    logic [STR_W-1:0]        prev_strength_reg, prev_strength_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [FRAME_W-1:0]      frames_reg, frames_next;
    logic                    zoomed_in_reg, zoomed_in_next;
    logic                    zoomed_out_reg, zoomed_out_next;

    // output register
    logic  m_valid_reg;
    zoom_t zoom_reg, zoom_next;
    logic  held_reg, held_next;

    logic               s_beat;
    logic               in_pinch, pinch_start;
    logic [DIST_W-1:0]  pinch_dist;
    logic [STR_W-1:0]   strength;
    logic [FRAME_W-1:0] frames_inc;

    logic signed [DIST_W:0]   delta;
    logic [DIST_W-1:0]        mag;
    logic signed [STR_W:0]    drop;
    logic signed [DIST_W:0]   cap_pos, cap_neg, capped;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  acc_sat, acc_half;
    logic signed [ACC_W-1:0]  step_pos, step_neg;

    assign in_pinch    = s_axis_tuser[0];
    assign pinch_start = s_axis_tuser[1];
    assign pinch_dist  = s_axis_tdata[DIST_W-1:0];
    assign strength    = s_axis_tdata[DIST_W+STR_W-1:DIST_W];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    assign frames_inc = (frames_reg == FRAMES_SAT) ? FRAMES_SAT : frames_reg + 8'd1;

    assign delta = $signed({1'b0, pinch_dist}) - $signed({1'b0, prev_distance_reg});
    assign mag   = delta[DIST_W] ? DIST_W'(-delta) : delta[DIST_W-1:0];
    assign drop  = $signed({1'b0, prev_strength_reg}) - $signed({1'b0, strength});

    assign cap_pos = $signed({1'b0, frame_cap_reg});
    assign cap_neg = -cap_pos;
    assign capped  = (delta > cap_pos) ? cap_pos : ((delta < cap_neg) ? cap_neg : delta);

    assign sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(capped);
    // saturate to the 20 bit signed range
    assign acc_sat = (sum[ACC_W] != sum[ACC_W-1]) ?
                     {sum[ACC_W], {(ACC_W-1){~sum[ACC_W]}}} : sum[ACC_W-1:0];

    // halve rounding toward zero
    assign acc_half = (acc_reg + ACC_W'($signed({1'b0, acc_reg[ACC_W-1]}))) >>> 1;

    assign step_pos = $signed({{(ACC_W-DIST_W){1'b0}}, step_size_reg});
    assign step_neg = -step_pos;

    always_comb begin
        baseline_valid_next = baseline_valid_reg;
        prev_distance_next  = prev_distance_reg;
        prev_strength_next  = prev_strength_reg;
        acc_next            = acc_reg;
        frames_next         = frames_inc;
        zoomed_in_next      = zoomed_in_reg;
        zoomed_out_next     = zoomed_out_reg;
        zoom_next           = ZOOM_NONE;
        held_next           = 1'b0;
        if (in_pinch) begin
            if (pinch_start || !baseline_valid_reg) begin
                baseline_valid_next = 1'b1;
                prev_distance_next  = pinch_dist;
                prev_strength_next  = strength;
                acc_next            = '0;
                zoomed_in_next      = 1'b0;
                zoomed_out_next     = 1'b0;
            end else begin
                prev_distance_next = pinch_dist;
                prev_strength_next = strength;
                if (strength < min_strength_reg) begin
                    // weak pinch, tracking only
                end else if (drop > $signed({1'b0, release_drop_reg})) begin
                    acc_next = acc_half;
                end else if (mag > max_delta_reg) begin
                    // glitch, frame dropped
                end else begin
                    acc_next = acc_sat;
                    if (frames_inc < RATE_LIMIT_FRAMES) begin
                        // rate limited
                    end else if (acc_sat >= step_pos) begin
                        acc_next       = '0;
                        frames_next    = '0;
                        zoomed_in_next = 1'b1;
                        zoom_next      = ZOOM_IN;
                    end else if (acc_sat <= step_neg) begin
                        acc_next        = '0;
                        frames_next     = '0;
                        zoomed_out_next = 1'b1;
                        zoom_next       = ZOOM_OUT;
                    end else if (zoomed_out_reg && pinch_dist < tight_limit_reg &&
                                 frames_inc >= continue_frames_reg) begin
                        frames_next = '0;
                        zoom_next   = ZOOM_OUT;
                        held_next   = 1'b1;
                    end else if (zoomed_in_reg && pinch_dist > wide_limit_reg &&
                                 frames_inc >= continue_frames_reg) begin
                        frames_next = '0;
                        zoom_next   = ZOOM_IN;
                        held_next   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_strength_reg    <= 9'd179;
            release_drop_reg    <= 9'd13;
            max_delta_reg       <= 14'd960;
            frame_cap_reg       <= 14'd192;
            step_size_reg       <= 14'd512;
            tight_limit_reg     <= 14'd1280;
            wide_limit_reg      <= 14'd5120;
            continue_frames_reg <= 8'd12;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MIN_STRENGTH:    min_strength_reg    <= cfg_wdata[STR_W-1:0];
                REG_RELEASE_DROP:    release_drop_reg    <= cfg_wdata[STR_W-1:0];
                REG_MAX_DELTA:       max_delta_reg       <= cfg_wdata;
                REG_FRAME_CAP:       frame_cap_reg       <= cfg_wdata;
                REG_STEP_SIZE:       step_size_reg       <= cfg_wdata;
                REG_TIGHT_LIMIT:     tight_limit_reg     <= cfg_wdata;
                REG_WIDE_LIMIT:      wide_limit_reg      <= cfg_wdata;
                REG_CONTINUE_FRAMES: continue_frames_reg <= cfg_wdata[FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_valid_reg <= 1'b0;
            prev_distance_reg  <= '0;
            prev_strength_reg  <= '0;
            acc_reg            <= '0;
            frames_reg         <= FRAMES_SAT;
            zoomed_in_reg      <= 1'b0;
            zoomed_out_reg     <= 1'b0;
        end else if (s_beat) begin
            baseline_valid_reg <= baseline_valid_next;
            prev_distance_reg  <= prev_distance_next;
            prev_strength_reg  <= prev_strength_next;
            acc_reg            <= acc_next;
            frames_reg         <= frames_next;
            zoomed_in_reg      <= zoomed_in_next;
            zoomed_out_reg     <= zoomed_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            zoom_reg <= zoom_next;
            held_reg <= held_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W-2){1'b0}}, zoom_reg};
    assign m_axis_tuser  = held_reg;

    a_held_has_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && held_reg |-> zoom_reg != ZOOM_NONE)
        else $error("held step without a direction");

    a_step_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (zoom_reg == ZOOM_NONE || zoom_reg == ZOOM_IN || zoom_reg == ZOOM_OUT))
        else $error("undefined zoom code");

    a_step_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && zoom_next != ZOOM_NONE |=> frames_reg == '0)
        else $error("frame count not cleared after a step");

    a_no_beat_holds_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_beat |=> $stable(acc_reg))
        else $error("accumulator moved without an input beat");

endmodule
